FILE: rtl/core/pmpe_pkg.sv
// shared constants, types and codes for the plus/minus/parentheses evaluator
// no dependencies; used by every file in rtl/core
package pmpe_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int ERR_W       = 2;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef logic [2:0] t_kind;
    localparam t_kind OP_NOP   = 3'd0;
    localparam t_kind OP_DIGIT = 3'd1;
    localparam t_kind OP_ADD   = 3'd2;
    localparam t_kind OP_SUB   = 3'd3;
    localparam t_kind OP_OPEN  = 3'd4;
    localparam t_kind OP_CLOSE = 3'd5;

    typedef logic [ERR_W-1:0] t_err;
    localparam t_err ERR_NONE  = 2'd0;
    localparam t_err ERR_DEEP  = 2'd1;
    localparam t_err ERR_CLOSE = 2'd2;
    localparam t_err ERR_OPEN  = 2'd3;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_op;

endpackage

FILE: rtl/core/pmpe_front.sv
// front end: classifies each input character and queues the decoded request
// depends on pmpe_pkg
module pmpe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_char_in,
    input  logic                i_last,
    output logic                o_q_valid,
    input  logic                i_q_take,
    output pmpe_pkg::t_op       o_q_op
);

    pmpe_pkg::t_op                  w_op;
    pmpe_pkg::t_op                  r_mem [pmpe_pkg::QUEUE_DEPTH];
    logic [pmpe_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [pmpe_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [pmpe_pkg::QCNT_W-1:0]    r_count;
    logic                           w_wr;
    logic                           w_rd;

    always_comb begin
        w_op.kind  = pmpe_pkg::OP_NOP;
        w_op.digit = 4'(i_char_in - pmpe_pkg::CH_ZERO);
        w_op.last  = i_last;
        if (i_char_in inside {[pmpe_pkg::CH_ZERO:pmpe_pkg::CH_NINE]}) begin
            w_op.kind = pmpe_pkg::OP_DIGIT;
        end else begin
            case (i_char_in)
                pmpe_pkg::CH_PLUS:  w_op.kind = pmpe_pkg::OP_ADD;
                pmpe_pkg::CH_MINUS: w_op.kind = pmpe_pkg::OP_SUB;
                pmpe_pkg::CH_OPEN:  w_op.kind = pmpe_pkg::OP_OPEN;
                pmpe_pkg::CH_CLOSE: w_op.kind = pmpe_pkg::OP_CLOSE;
                default:            w_op.kind = pmpe_pkg::OP_NOP;
            endcase
        end
    end

    assign full      = (r_count == pmpe_pkg::QCNT_W'(pmpe_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_op    = r_mem[r_rd_ptr];
    assign w_wr      = push && !full;
    assign w_rd      = o_q_valid && i_q_take;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == pmpe_pkg::QPTR_W'(pmpe_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == pmpe_pkg::QPTR_W'(pmpe_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/pmpe_back.sv
// back end: runs decoded requests against the sum, number, sign and paren stack
// depends on pmpe_pkg; holds the result register seen on the output ports
module pmpe_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_take,
    input  pmpe_pkg::t_op                       i_q_op,
    output logic                                empty,
    input  logic                                pop,
    output logic [pmpe_pkg::OUT_W-1:0]          o_value,
    output pmpe_pkg::t_err                      o_error
);

    logic [pmpe_pkg::VALUE_WIDTH-1:0]   r_sum, n_sum;
    logic [pmpe_pkg::VALUE_WIDTH-1:0]   r_num, n_num;
    logic                               r_sign, n_sign;
    logic [pmpe_pkg::LEVEL_W-1:0]       r_level, n_level;
    pmpe_pkg::t_err                     r_err, n_err;

    logic [pmpe_pkg::VALUE_WIDTH-1:0]   r_saved_sum  [pmpe_pkg::STACK_DEPTH];
    logic                               r_saved_sign [pmpe_pkg::STACK_DEPTH];

    logic                               r_out_valid;
    logic [pmpe_pkg::VALUE_WIDTH-1:0]   r_out_value;
    pmpe_pkg::t_err                     r_out_error;

    logic [pmpe_pkg::VALUE_WIDTH-1:0]   w_term;
    logic [pmpe_pkg::VALUE_WIDTH-1:0]   w_folded;
    logic [pmpe_pkg::VALUE_WIDTH-1:0]   w_tail;
    logic [pmpe_pkg::VALUE_WIDTH-1:0]   w_final;
    logic [pmpe_pkg::VALUE_WIDTH-1:0]   w_top_sum;
    logic                               w_top_sign;
    logic [pmpe_pkg::LEVEL_W-1:0]       w_level_dn;
    logic [pmpe_pkg::IDX_W-1:0]         w_pop_idx;
    logic [pmpe_pkg::IDX_W-1:0]         w_push_idx;
    logic                               w_push;
    pmpe_pkg::t_err                     w_final_err;
    logic                               w_go;

    // a result can only be held up by a full result register
    assign o_q_take = !(i_q_op.last && r_out_valid && !pop);
    assign w_go     = i_q_valid && o_q_take;

    assign w_level_dn = r_level - 1'b1;
    assign w_pop_idx  = w_level_dn[pmpe_pkg::IDX_W-1:0];
    assign w_push_idx = r_level[pmpe_pkg::IDX_W-1:0];
    assign w_top_sum  = r_saved_sum[w_pop_idx];
    assign w_top_sign = r_saved_sign[w_pop_idx];

    assign w_term   = r_sign ? (-r_num) : r_num;
    assign w_folded = r_sum + w_term;

    always_comb begin
        n_sum   = r_sum;
        n_num   = r_num;
        n_sign  = r_sign;
        n_level = r_level;
        n_err   = r_err;
        w_push  = 1'b0;
        case (i_q_op.kind)
            pmpe_pkg::OP_DIGIT: begin
                n_num = (r_num << 3) + (r_num << 1)
                        + pmpe_pkg::VALUE_WIDTH'(i_q_op.digit);
            end
            pmpe_pkg::OP_ADD, pmpe_pkg::OP_SUB: begin
                n_sum  = w_folded;
                n_num  = '0;
                n_sign = (i_q_op.kind == pmpe_pkg::OP_SUB);
            end
            pmpe_pkg::OP_OPEN: begin
                n_sum = w_folded;
                n_num = '0;
                if (r_level < pmpe_pkg::LEVEL_W'(pmpe_pkg::STACK_DEPTH)) begin
                    w_push  = 1'b1;
                    n_level = r_level + 1'b1;
                    n_sum   = '0;
                    n_sign  = 1'b0;
                end else if (r_err == pmpe_pkg::ERR_NONE) begin
                    n_err = pmpe_pkg::ERR_DEEP;
                end
            end
            pmpe_pkg::OP_CLOSE: begin
                n_sum = w_folded;
                n_num = '0;
                if (r_level == '0) begin
                    if (r_err == pmpe_pkg::ERR_NONE) begin
                        n_err = pmpe_pkg::ERR_CLOSE;
                    end
                end else begin
                    n_sum   = w_top_sum + (w_top_sign ? (-w_folded) : w_folded);
                    n_level = w_level_dn;
                    n_sign  = 1'b0;
                end
            end
            default: begin
                n_sum = r_sum;
            end
        endcase
    end

    // closing fold for the final character
    assign w_tail      = n_sign ? (-n_num) : n_num;
    assign w_final     = n_sum + w_tail;
    assign w_final_err = (n_err == pmpe_pkg::ERR_NONE && n_level != '0)
                         ? pmpe_pkg::ERR_OPEN : n_err;

    always_ff @(posedge i_clk) begin
        if (w_go && w_push) begin
            r_saved_sum[w_push_idx]  <= w_folded;
            r_saved_sign[w_push_idx] <= r_sign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && i_q_op.last) begin
            r_out_value <= (w_final_err == pmpe_pkg::ERR_NONE) ? w_final : '0;
            r_out_error <= w_final_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_num       <= '0;
            r_sign      <= 1'b0;
            r_level     <= '0;
            r_err       <= pmpe_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                if (i_q_op.last) begin
                    r_sum   <= '0;
                    r_num   <= '0;
                    r_sign  <= 1'b0;
                    r_level <= '0;
                    r_err   <= pmpe_pkg::ERR_NONE;
                end else begin
                    r_sum   <= n_sum;
                    r_num   <= n_num;
                    r_sign  <= n_sign;
                    r_level <= n_level;
                    r_err   <= n_err;
                end
            end
            if (w_go && i_q_op.last) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty   = !r_out_valid;
    assign o_value = pmpe_pkg::OUT_W'($signed(r_out_value));
    assign o_error = r_out_error;

endmodule

FILE: rtl/core/plus_minus_paren_expression_eval_top.sv
// channel   direction  handshake         payload
// input     in         push / full       i_char_in[7:0], i_last
// result    out        empty / pop       o_value[31:0] (signed), o_error[1:0]
//
// one character per cycle sustained unless a held result stalls the evaluator; each
// request passes the decode queue, and the result register loads on its last char.
// the evaluator's per-request update (fold, stack push or pop) sets the rate.
// synchronous active-low reset empties both queues and clears the evaluator.
// only the final character of an expression waits on a held result.
// depends on pmpe_pkg, pmpe_front, pmpe_back
module plus_minus_paren_expression_eval_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_char_in,
    input  logic                        i_last,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [31:0]          o_value,
    output logic [1:0]                  o_error
);

    logic               w_q_valid;
    logic               w_q_take;
    pmpe_pkg::t_op      w_q_op;

    pmpe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_char_in (i_char_in),
        .i_last    (i_last),
        .o_q_valid (w_q_valid),
        .i_q_take  (w_q_take),
        .o_q_op    (w_q_op)
    );

    pmpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_take  (w_q_take),
        .i_q_op    (w_q_op),
        .empty     (empty),
        .pop       (pop),
        .o_value   (o_value),
        .o_error   (o_error)
    );

`ifndef SYNTHESIS
    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error != pmpe_pkg::ERR_NONE) |-> (o_value == '0))
        else $error("result with error carries nonzero value");

    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && !w_q_take) |-> (w_q_op.last && !empty && !pop))
        else $error("evaluator stalled on a request that makes no result");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_q_op.last && !empty && !pop) |-> !w_q_take)
        else $error("result register overwritten while held");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule
